FILE: src/tak_pkg.sv
// ----------------------------------------------------------------------------
// Thermistor ADC to kelvin: shared package
// Widths, constants, register indexes and the stage-to-stage structs that
// the pipeline modules of the thermistor converter use.
// ----------------------------------------------------------------------------
package tak_pkg;

	// Converter and output formats.
	localparam int ADC_W         = 10;
	localparam int ADC_BITS      = 10;
	localparam int OUT_FRAC_BITS = 8;
	localparam int OUT_W         = 18;
	localparam int COEF_W        = 32;
	localparam int DIV_W         = 20;
	localparam int CFG_IDX_W     = 2;

	// Resistance divider: R is Q16 and always below the divider value.
	localparam int R_FRAC = 16;
	localparam int R_W    = DIV_W + R_FRAC;
	localparam int NUM_W  = DIV_W + ADC_BITS;
	localparam int DEN_W  = ADC_BITS + 1;

	// Logarithm: leading-one position plus a Q30 mantissa squared once per bit.
	localparam int P_W      = $clog2(R_W);
	localparam int M_W      = 31;
	localparam int LOG_FRAC = 28;
	localparam int LG_W     = P_W + LOG_FRAC;
	localparam int LGM_W    = LG_W - 1;

	// Polynomial term widths (magnitudes unless noted).
	localparam int LN_W  = 32;
	localparam int LN2_W = 36;
	localparam int LN3_W = 40;
	localparam int BT_W  = 36;
	localparam int CT_W  = 44;
	localparam int D1_W  = 38;
	localparam int D_W   = 47;
	localparam int DM_W  = D_W - 1;

	// Reciprocal: dividend 2^(40+F) plus half the denominator.
	localparam int DEN_EXP = 40 + OUT_FRAC_BITS;
	localparam int NR_W    = 47 + OUT_FRAC_BITS;

	localparam logic [LOG_FRAC-1:0] LN2_Q28 = 28'd186065280;
	localparam logic [OUT_W-1:0]    OUT_MAX = '1;

	// Register reset values.
	localparam logic [COEF_W-1:0] COEF_A_RST  = 32'd1319413953;
	localparam logic [COEF_W-1:0] COEF_B_RST  = 32'd196909040;
	localparam logic [COEF_W-1:0] COEF_C_RST  = 32'd320936;
	localparam logic [DIV_W-1:0]  DIVIDER_RST = 20'd32500;

	// Register indexes of the write port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_A  = 2'd0,
		REG_COEF_B  = 2'd1,
		REG_COEF_C  = 2'd2,
		REG_DIVIDER = 2'd3
	} reg_idx_t;

	// Resistance word leaving the divider.
	typedef struct packed {
		logic           vld;
		logic           dom;
		logic [R_W-1:0] r;
	} res_t;

	// Signed Q28 base-two logarithm.
	typedef struct packed {
		logic                   vld;
		logic                   dom;
		logic signed [LG_W-1:0] lg;
	} log_t;

	// Signed Q40 Steinhart-Hart denominator.
	typedef struct packed {
		logic                  vld;
		logic                  dom;
		logic signed [D_W-1:0] d;
	} den_t;

endpackage

FILE: src/thermistor_adc_to_kelvin_unit.sv
// ----------------------------------------------------------------------------
// Thermistor ADC to kelvin converter, top level
// Throughput: one sample word per cycle; the whole pipeline holds while a
// finished result word is stalled at the output register.
// Reset: arst_n clears all valid bits and loads the coefficient and divider
// registers with their default values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module thermistor_adc_to_kelvin_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tak_pkg::ADC_W-1:0]     adc_sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tak_pkg::OUT_W-1:0]     kelvin_q8,
	output logic                          domain_error,
	input  logic                          wr_en,
	input  logic [tak_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [tak_pkg::COEF_W-1:0]    wr_data
);

	logic [tak_pkg::COEF_W-1:0] coef_a_q;
	logic [tak_pkg::COEF_W-1:0] coef_b_q;
	logic [tak_pkg::COEF_W-1:0] coef_c_q;
	logic [tak_pkg::DIV_W-1:0]  divider_q;
	logic                       en;

	tak_pkg::res_t res;
	tak_pkg::log_t lg;
	tak_pkg::den_t den;

	// The pipeline advances unless the output word is held.
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q  <= tak_pkg::COEF_A_RST;
			coef_b_q  <= tak_pkg::COEF_B_RST;
			coef_c_q  <= tak_pkg::COEF_C_RST;
			divider_q <= tak_pkg::DIVIDER_RST;
		end else if (wr_en) begin
			unique case (tak_pkg::reg_idx_t'(wr_index))
				tak_pkg::REG_COEF_A:  coef_a_q  <= wr_data;
				tak_pkg::REG_COEF_B:  coef_b_q  <= wr_data;
				tak_pkg::REG_COEF_C:  coef_c_q  <= wr_data;
				tak_pkg::REG_DIVIDER: divider_q <= wr_data[tak_pkg::DIV_W-1:0];
				default: ;
			endcase
		end
	end

	tak_res_div u_res_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.sample  (adc_sample),
		.divider (divider_q),
		.res     (res)
	);

	tak_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.res    (res),
		.lg     (lg)
	);

	tak_poly u_poly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.lg     (lg),
		.coef_a (coef_a_q),
		.coef_b (coef_b_q),
		.coef_c (coef_c_q),
		.den    (den)
	);

	tak_recip u_recip (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.den          (den),
		.out_valid    (out_valid),
		.kelvin_q8    (kelvin_q8),
		.domain_error (domain_error)
	);

endmodule

FILE: src/tak_res_div.sv
// ----------------------------------------------------------------------------
// Thermistor resistance divider
// Forms divider_ohms * s and divides its Q16 value by (2^ADC_BITS + s) with
// a restoring divider that resolves one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module tak_res_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [tak_pkg::ADC_W-1:0]   sample,
	input  logic [tak_pkg::DIV_W-1:0]   divider,
	output tak_pkg::res_t               res
);

	localparam int NST = tak_pkg::R_W;

	logic [NST:0]                    vld_s;
	logic                            dom_s [0:NST];
	logic [tak_pkg::NUM_W-1:0]       num_s [0:NST];
	logic [tak_pkg::DEN_W-1:0]       den_s [0:NST];
	logic [tak_pkg::DEN_W-1:0]       rem_s [1:NST];
	logic [tak_pkg::R_W-1:0]         quo_s [1:NST];
	logic [tak_pkg::ADC_BITS-1:0]    smp;

	assign smp = sample[tak_pkg::ADC_BITS-1:0];

	// Valid bits travel with the words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-1:0], in_vld};
		end
	end

	// Entry stage: numerator product and denominator.
	always_ff @(posedge clk) begin
		if (en) begin
			dom_s[0] <= (smp == '0);
			num_s[0] <= divider * smp;
			den_s[0] <= tak_pkg::DEN_W'(1 << tak_pkg::ADC_BITS) + tak_pkg::DEN_W'(smp);
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar k = 0; k < NST; k++) begin : g_div
		localparam int BI = NST - 1 - k;
		logic                        nbit;
		logic [tak_pkg::DEN_W-1:0]   rem_c;
		logic [tak_pkg::R_W-1:0]     quo_c;
		logic [tak_pkg::DEN_W:0]     trial;
		logic [tak_pkg::DEN_W:0]     diff;
		logic                        ge;

		if (BI >= tak_pkg::R_FRAC) begin : g_nb
			assign nbit = num_s[k][BI-tak_pkg::R_FRAC];
		end else begin : g_nz
			assign nbit = 1'b0;
		end

		if (k == 0) begin : g_first
			// The bits above the quotient range stay below the denominator.
			assign rem_c = tak_pkg::DEN_W'(num_s[0] >> (tak_pkg::R_W - tak_pkg::R_FRAC));
			assign quo_c = '0;
		end else begin : g_next
			assign rem_c = rem_s[k];
			assign quo_c = quo_s[k];
		end

		assign trial = {rem_c, nbit};
		assign diff  = trial - {1'b0, den_s[k]};
		assign ge    = (trial >= {1'b0, den_s[k]});

		always_ff @(posedge clk) begin
			if (en) begin
				dom_s[k+1] <= dom_s[k];
				num_s[k+1] <= num_s[k];
				den_s[k+1] <= den_s[k];
				rem_s[k+1] <= ge ? diff[tak_pkg::DEN_W-1:0] : trial[tak_pkg::DEN_W-1:0];
				quo_s[k+1] <= {quo_c[tak_pkg::R_W-2:0], ge};
			end
		end
	end

	assign res.vld = vld_s[NST];
	assign res.dom = dom_s[NST];
	assign res.r   = quo_s[NST];

endmodule

FILE: src/tak_log2.sv
// ----------------------------------------------------------------------------
// Thermistor base-two logarithm
// Finds the leading one of the Q16 resistance, normalizes it to a Q30
// mantissa and squares it once per stage to produce 28 fraction bits.
// ----------------------------------------------------------------------------
module tak_log2 (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  tak_pkg::res_t res,
	output tak_pkg::log_t lg
);

	localparam int NSQ = tak_pkg::LOG_FRAC;

	// Leading-one stage registers.
	logic                        vld_s1;
	logic                        dom_s1;
	logic [tak_pkg::R_W-1:0]     r_s1;
	logic [tak_pkg::P_W-1:0]     p_s1;
	logic [tak_pkg::P_W-1:0]     p_c;

	// Squaring chain, index 0 is the normalize stage.
	logic [NSQ:0]                   vld_s;
	logic                           dom_s  [0:NSQ];
	logic [tak_pkg::P_W-1:0]        p_s    [0:NSQ];
	logic [tak_pkg::M_W-1:0]        m_s    [0:NSQ];
	logic [tak_pkg::LOG_FRAC-1:0]   frac_s [0:NSQ];

	logic [tak_pkg::P_W-1:0]     sh;
	logic [tak_pkg::R_W-1:0]     norm;
	logic [tak_pkg::P_W-1:0]     pm16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s  <= '0;
		end else if (en) begin
			vld_s1 <= res.vld;
			vld_s  <= {vld_s[NSQ-1:0], vld_s1};
		end
	end

	// Position of the leading one; a zero resistance is a domain error.
	always_comb begin
		p_c = '0;
		for (int i = 0; i < tak_pkg::R_W; i++) begin
			if (res.r[i]) begin
				p_c = tak_pkg::P_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dom_s1 <= res.dom | (res.r == '0);
			r_s1   <= res.r;
			p_s1   <= p_c;
		end
	end

	// Normalize so the leading one sits at bit 30 of the mantissa.
	assign sh   = tak_pkg::P_W'(tak_pkg::R_W - 1) - p_s1;
	assign norm = r_s1 << sh;

	always_ff @(posedge clk) begin
		if (en) begin
			dom_s[0]  <= dom_s1;
			p_s[0]    <= p_s1;
			m_s[0]    <= norm[tak_pkg::R_W-1 -: tak_pkg::M_W];
			frac_s[0] <= '0;
		end
	end

	// Each squaring yields one fraction bit and renormalizes the mantissa.
	for (genvar k = 0; k < NSQ; k++) begin : g_sq
		logic [2*tak_pkg::M_W-1:0] prod;
		logic [tak_pkg::M_W:0]     sq;
		logic                      bit_c;

		assign prod  = m_s[k] * m_s[k];
		assign sq    = prod[tak_pkg::M_W-1 +: tak_pkg::M_W+1];
		assign bit_c = sq[tak_pkg::M_W];

		always_ff @(posedge clk) begin
			if (en) begin
				dom_s[k+1]  <= dom_s[k];
				p_s[k+1]    <= p_s[k];
				m_s[k+1]    <= bit_c ? sq[tak_pkg::M_W:1] : sq[tak_pkg::M_W-1:0];
				frac_s[k+1] <= {frac_s[k][tak_pkg::LOG_FRAC-2:0], bit_c};
			end
		end
	end

	// Integer part is the leading-one position less the Q16 scale.
	assign pm16   = p_s[NSQ] - tak_pkg::P_W'(tak_pkg::R_FRAC);
	assign lg.vld = vld_s[NSQ];
	assign lg.dom = dom_s[NSQ];
	assign lg.lg  = $signed({pm16, frac_s[NSQ]});

endmodule

FILE: src/tak_poly.sv
// ----------------------------------------------------------------------------
// Thermistor Steinhart-Hart polynomial
// Converts log2 R to ln R and evaluates A + B ln R + C (ln R)^3 on
// magnitudes with truncation toward zero, one multiplier rank per stage.
// ----------------------------------------------------------------------------
module tak_poly (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  tak_pkg::log_t              lg,
	input  logic [tak_pkg::COEF_W-1:0] coef_a,
	input  logic [tak_pkg::COEF_W-1:0] coef_b,
	input  logic [tak_pkg::COEF_W-1:0] coef_c,
	output tak_pkg::den_t              den
);

	localparam int NST = 8;
	localparam int F   = tak_pkg::LOG_FRAC;

	logic [NST:1] vld_s;
	logic [NST:1] dom_s;

	// Coefficient magnitudes and signs, held steady between writes.
	logic [tak_pkg::COEF_W-1:0] cb_mag_q;
	logic [tak_pkg::COEF_W-1:0] cc_mag_q;
	logic                       cb_neg_q;
	logic                       cc_neg_q;

	logic                        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [tak_pkg::LGM_W-1:0]   mag_s1;
	logic [tak_pkg::LN_W-1:0]    ln_s2, ln_s3;
	logic [tak_pkg::LN2_W-1:0]   ln2_s3;
	logic [tak_pkg::BT_W-1:0]    bmag_s3;
	logic                        bneg_s3;
	logic [2*tak_pkg::LN_W-1:0]  lo_s4;
	logic [tak_pkg::LN_W+3:0]    hi_s4;
	logic signed [tak_pkg::D1_W-1:0] d1_s4, d1_s5, d1_s6, d1_s7;
	logic [tak_pkg::LN3_W-1:0]   ln3_s5;
	logic [2*tak_pkg::COEF_W-1:0] clo_s6;
	logic [tak_pkg::COEF_W+7:0]  chi_s6;
	logic                        cneg_s6, cneg_s7;
	logic [tak_pkg::CT_W-1:0]    cmag_s7;
	logic signed [tak_pkg::D_W-1:0] d_s8;

	logic [tak_pkg::LG_W-1:0]       lg_neg;
	logic [tak_pkg::LGM_W+F-1:0]    p2;
	logic [2*tak_pkg::LN_W-1:0]     p3_sq;
	logic [2*tak_pkg::LN_W-1:0]     p3_b;
	logic signed [tak_pkg::D1_W-1:0] bterm;
	logic signed [tak_pkg::D1_W-1:0] aterm;
	logic [tak_pkg::LN2_W+tak_pkg::LN_W-1:0] t5;
	logic [tak_pkg::CT_W+F-1:0]     t7;
	logic signed [tak_pkg::D_W-1:0] cterm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-1:1], lg.vld};
		end
	end

	always_ff @(posedge clk) begin
		cb_mag_q <= coef_b[tak_pkg::COEF_W-1] ? -coef_b : coef_b;
		cb_neg_q <= coef_b[tak_pkg::COEF_W-1];
		cc_mag_q <= coef_c[tak_pkg::COEF_W-1] ? -coef_c : coef_c;
		cc_neg_q <= coef_c[tak_pkg::COEF_W-1];
	end

	// Stage 1: sign and magnitude of log2 R.
	assign lg_neg = -lg.lg;

	// Stage 2: ln R = log2 R * ln 2.
	assign p2 = mag_s1 * tak_pkg::LN2_Q28;

	// Stage 3: (ln R)^2 and the B term.
	assign p3_sq = ln_s2 * ln_s2;
	assign p3_b  = cb_mag_q * ln_s2;

	// Stage 4: partial products of (ln R)^3 and the A plus B sum.
	always_comb begin
		bterm = $signed(tak_pkg::D1_W'(bmag_s3));
		if (bneg_s3) begin
			bterm = -bterm;
		end
		aterm = $signed({{(tak_pkg::D1_W-tak_pkg::COEF_W){coef_a[tak_pkg::COEF_W-1]}},
			coef_a});
	end

	// Stage 5: recombine (ln R)^3.
	assign t5 = {hi_s4, 32'b0} + {4'b0, lo_s4};

	// Stage 7: recombine the C term.
	assign t7 = {chi_s6, 32'b0} + {8'b0, clo_s6};

	// Stage 8: full denominator.
	always_comb begin
		cterm = $signed(tak_pkg::D_W'(cmag_s7));
		if (cneg_s7) begin
			cterm = -cterm;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dom_s   <= {dom_s[NST-1:1], lg.dom};
			neg_s1  <= lg.lg[tak_pkg::LG_W-1];
			mag_s1  <= lg_neg[tak_pkg::LG_W-1] ? lg.lg[tak_pkg::LGM_W-1:0]
				: lg_neg[tak_pkg::LGM_W-1:0];
			neg_s2  <= neg_s1;
			ln_s2   <= p2[F +: tak_pkg::LN_W];
			neg_s3  <= neg_s2;
			ln_s3   <= ln_s2;
			ln2_s3  <= p3_sq[F +: tak_pkg::LN2_W];
			bmag_s3 <= p3_b[F +: tak_pkg::BT_W];
			bneg_s3 <= cb_neg_q ^ neg_s2;
			neg_s4  <= neg_s3;
			lo_s4   <= ln2_s3[31:0] * ln_s3;
			hi_s4   <= ln2_s3[tak_pkg::LN2_W-1:32] * ln_s3;
			d1_s4   <= aterm + bterm;
			neg_s5  <= neg_s4;
			d1_s5   <= d1_s4;
			ln3_s5  <= t5[F +: tak_pkg::LN3_W];
			d1_s6   <= d1_s5;
			clo_s6  <= cc_mag_q * ln3_s5[31:0];
			chi_s6  <= cc_mag_q * ln3_s5[tak_pkg::LN3_W-1:32];
			cneg_s6 <= cc_neg_q ^ neg_s5;
			d1_s7   <= d1_s6;
			cmag_s7 <= t7[F +: tak_pkg::CT_W];
			cneg_s7 <= cneg_s6;
			d_s8    <= $signed({{(tak_pkg::D_W-tak_pkg::D1_W){d1_s7[tak_pkg::D1_W-1]}}, d1_s7})
				+ cterm;
		end
	end

	assign den.vld = vld_s[NST];
	assign den.dom = dom_s[NST];
	assign den.d   = d_s8;

endmodule

FILE: src/tak_recip.sv
// ----------------------------------------------------------------------------
// Thermistor reciprocal and output register
// Rounds 2^(40+F) / D with a restoring divider, one bit per stage, detects
// overflow up front, and holds the result word for the output channel.
// ----------------------------------------------------------------------------
module tak_recip (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  tak_pkg::den_t             den,
	output logic                      out_valid,
	output logic [tak_pkg::OUT_W-1:0] kelvin_q8,
	output logic                      domain_error
);

	localparam int NST = tak_pkg::OUT_W;
	localparam int HI_W = tak_pkg::NR_W - tak_pkg::OUT_W;

	logic                        vld_s1, dom_s1, neg_s1;
	logic [tak_pkg::NR_W-1:0]    n_s1;
	logic [tak_pkg::DM_W-1:0]    dm_s1;

	logic [NST:0]                vld_s;
	logic                        dom_s  [0:NST];
	logic                        neg_s  [0:NST];
	logic                        ovf_s  [0:NST];
	logic [tak_pkg::DM_W-1:0]    dm_s   [0:NST];
	logic [tak_pkg::DM_W-1:0]    rem_s  [0:NST];
	logic [tak_pkg::OUT_W-1:0]   nlo_s  [0:NST];
	logic [tak_pkg::OUT_W-1:0]   quo_s  [0:NST];

	logic [tak_pkg::DM_W-1:0]    dm_c;
	logic [HI_W-1:0]             hi_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s     <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= den.vld;
			vld_s     <= {vld_s[NST-1:0], vld_s1};
			out_valid <= vld_s[NST];
		end
	end

	// Stage 1: dividend with half the divisor added for rounding.
	assign dm_c = den.d[tak_pkg::DM_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			dom_s1 <= den.dom;
			neg_s1 <= den.d[tak_pkg::D_W-1];
			dm_s1  <= dm_c;
			n_s1   <= (tak_pkg::NR_W'(1) << tak_pkg::DEN_EXP)
				+ tak_pkg::NR_W'(dm_c >> 1);
		end
	end

	// Stage 2: a quotient of 2^18 or more saturates, as does a zero divisor.
	assign hi_c = n_s1[tak_pkg::NR_W-1:tak_pkg::OUT_W];

	always_ff @(posedge clk) begin
		if (en) begin
			dom_s[0] <= dom_s1;
			neg_s[0] <= neg_s1;
			ovf_s[0] <= (tak_pkg::DM_W'(hi_c) >= dm_s1);
			dm_s[0]  <= dm_s1;
			rem_s[0] <= tak_pkg::DM_W'(hi_c);
			nlo_s[0] <= n_s1[tak_pkg::OUT_W-1:0];
			quo_s[0] <= '0;
		end
	end

	// One quotient bit per stage.
	for (genvar k = 0; k < NST; k++) begin : g_div
		logic [tak_pkg::DM_W:0] trial;
		logic [tak_pkg::DM_W:0] diff;
		logic                   ge;

		assign trial = {rem_s[k], nlo_s[k][tak_pkg::OUT_W-1-k]};
		assign diff  = trial - {1'b0, dm_s[k]};
		assign ge    = (trial >= {1'b0, dm_s[k]});

		always_ff @(posedge clk) begin
			if (en) begin
				dom_s[k+1] <= dom_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
				dm_s[k+1]  <= dm_s[k];
				nlo_s[k+1] <= nlo_s[k];
				rem_s[k+1] <= ge ? diff[tak_pkg::DM_W-1:0] : trial[tak_pkg::DM_W-1:0];
				quo_s[k+1] <= {quo_s[k][tak_pkg::OUT_W-2:0], ge};
			end
		end
	end

	// Output register: zero below range or on a domain error, saturate on overflow, else the quotient.
	always_ff @(posedge clk) begin
		if (en) begin
			domain_error <= dom_s[NST];
			if (dom_s[NST] || neg_s[NST]) begin
				kelvin_q8 <= '0;
			end else if (ovf_s[NST]) begin
				kelvin_q8 <= tak_pkg::OUT_MAX;
			end else begin
				kelvin_q8 <= quo_s[NST];
			end
		end
	end

endmodule

FILE: sim/thermistor_adc_to_kelvin_checker.sv
// ----------------------------------------------------------------------------
// Thermistor ADC to kelvin: result checker
// Watches the sample and result channels and the register write port, keeps
// its own copy of the coefficients, computes the expected temperature word
// for every accepted sample and compares it with the result words in order.
// ----------------------------------------------------------------------------
module thermistor_adc_to_kelvin_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [tak_pkg::ADC_W-1:0]     adc_sample,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [tak_pkg::OUT_W-1:0]     kelvin_q8,
	input  logic                          domain_error,
	input  logic                          wr_en,
	input  logic [tak_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [tak_pkg::COEF_W-1:0]    wr_data,
	output int                            fail_count,
	output int                            pending_count,
	output int                            result_count,
	output int                            domain_count,
	output int                            sat_count
);

	typedef struct {
		logic [tak_pkg::OUT_W-1:0] kelvin;
		logic                      dom;
	} temp_word_t;

	localparam logic [63:0] CLAMP = 64'd1 << 61;

	temp_word_t                temp_queue[$];
	longint                    coef_a_q40, coef_b_q40, coef_c_q40;
	logic [tak_pkg::DIV_W-1:0] divider;

	// Magnitude product shifted right, clamped to the saturation magnitude.
	function automatic logic [63:0] mag_mul_shr(logic [63:0] a, logic [63:0] b, int s);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> s;
		return (p > {64'd0, CLAMP}) ? CLAMP : p[63:0];
	endfunction

	// Signed product, truncated toward zero.
	function automatic longint sgn_mul_shr(longint a, longint b, int s);
		logic [63:0] m;
		m = mag_mul_shr(a < 0 ? -a : a, b < 0 ? -b : b, s);
		return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clamp_sum(longint v);
		if (v > longint'(CLAMP))
			return longint'(CLAMP);
		if (v < -longint'(CLAMP))
			return -longint'(CLAMP);
		return v;
	endfunction

	// Base-two logarithm of a positive Q16 value, Q28 result.
	function automatic longint log2_q28(logic [63:0] x);
		int          pos;
		logic [63:0] m;
		longint      frac;
		pos = 0;
		frac = 0;
		while ((x >> pos) > 1)
			pos++;
		m = (pos >= 30) ? (x >> (pos - 30)) : (x << (30 - pos));
		for (int i = 0; i < 28; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return longint'(pos - 16) * (longint'(1) << 28) + frac;
	endfunction

	function automatic temp_word_t kelvin_of_sample(logic [tak_pkg::ADC_W-1:0] smp);
		temp_word_t  w;
		logic [63:0] r_q16, t;
		longint      ln, ln2, ln3, d;
		w.kelvin = '0;
		w.dom = 1'b0;
		if (smp == 0) begin
			w.dom = 1'b1;
			return w;
		end
		r_q16 = ((64'(divider) * 64'(smp)) << 16)
			/ ((64'd1 << tak_pkg::ADC_BITS) + 64'(smp));
		if (r_q16 == 0) begin
			w.dom = 1'b1;
			return w;
		end
		ln = sgn_mul_shr(log2_q28(r_q16), longint'(tak_pkg::LN2_Q28), 28);
		ln2 = sgn_mul_shr(ln, ln, 28);
		ln3 = sgn_mul_shr(ln2, ln, 28);
		d = clamp_sum(coef_a_q40 + sgn_mul_shr(coef_b_q40, ln, 28));
		d = clamp_sum(d + sgn_mul_shr(coef_c_q40, ln3, 28));
		if (d == 0) begin
			w.kelvin = tak_pkg::OUT_MAX;
		end else if (d > 0) begin
			t = ((64'd1 << tak_pkg::DEN_EXP) + (64'(d) >> 1)) / 64'(d);
			w.kelvin = (t > 64'(tak_pkg::OUT_MAX)) ? tak_pkg::OUT_MAX
				: t[tak_pkg::OUT_W-1:0];
		end
		return w;
	endfunction

	// Track register writes, predict on accepted samples, check result words.
	always @(posedge clk or negedge arst_n) begin
		temp_word_t want;
		if (!arst_n) begin
			coef_a_q40 <= longint'(signed'(tak_pkg::COEF_A_RST));
			coef_b_q40 <= longint'(signed'(tak_pkg::COEF_B_RST));
			coef_c_q40 <= longint'(signed'(tak_pkg::COEF_C_RST));
			divider <= tak_pkg::DIVIDER_RST;
			temp_queue.delete();
			fail_count <= 0;
			pending_count <= 0;
			result_count <= 0;
			domain_count <= 0;
			sat_count <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				result_count <= result_count + 1;
				if (domain_error)
					domain_count <= domain_count + 1;
				if (kelvin_q8 == tak_pkg::OUT_MAX)
					sat_count <= sat_count + 1;
				if (temp_queue.size() == 0) begin
					$display("%0t: unexpected result word kelvin_q8=%0d domain_error=%0d",
						$time, kelvin_q8, domain_error);
					fail_count <= fail_count + 1;
				end else begin
					want = temp_queue.pop_front();
					if (want.kelvin !== kelvin_q8 || want.dom !== domain_error) begin
						$display("%0t: mismatch expected kelvin_q8=%0d domain_error=%0d,",
							$time, want.kelvin, want.dom,
							" actual kelvin_q8=%0d domain_error=%0d",
							kelvin_q8, domain_error);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				temp_queue = {temp_queue, kelvin_of_sample(adc_sample)};
			pending_count <= temp_queue.size();
			if (wr_en) begin
				case (tak_pkg::reg_idx_t'(wr_index))
					tak_pkg::REG_COEF_A: coef_a_q40 <= longint'(signed'(wr_data));
					tak_pkg::REG_COEF_B: coef_b_q40 <= longint'(signed'(wr_data));
					tak_pkg::REG_COEF_C: coef_c_q40 <= longint'(signed'(wr_data));
					tak_pkg::REG_DIVIDER: divider <= wr_data[tak_pkg::DIV_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

FILE: sim/thermistor_adc_to_kelvin_unit_test.sv
// ----------------------------------------------------------------------------
// Thermistor ADC to kelvin: testbench top
// Drives directed and random sample words through several coefficient and
// divider settings with random gaps on both channels and one long output
// hold-off, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module thermistor_adc_to_kelvin_unit_test;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [tak_pkg::ADC_W-1:0]     adc_sample;
	logic                          out_valid;
	logic                          out_stall;
	logic [tak_pkg::OUT_W-1:0]     kelvin_q8;
	logic                          domain_error;
	logic                          wr_en;
	logic [tak_pkg::CFG_IDX_W-1:0] wr_index;
	logic [tak_pkg::COEF_W-1:0]    wr_data;
	int                   fail_count, pending_count, result_count, domain_count, sat_count;
	int                   sent_count;
	bit                   quiet_tail;
	bit                   hold_request;

	localparam int PIPE_LATENCY = 96;

	thermistor_adc_to_kelvin_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .adc_sample(adc_sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.kelvin_q8(kelvin_q8), .domain_error(domain_error),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	thermistor_adc_to_kelvin_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .adc_sample(adc_sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.kelvin_q8(kelvin_q8), .domain_error(domain_error),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.fail_count(fail_count), .pending_count(pending_count),
		.result_count(result_count), .domain_count(domain_count), .sat_count(sat_count)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Hard limit on the run time.
	initial begin
		#3000000;
		$display("Timeout with %0d result words outstanding", pending_count);
		$display("Test completed with failures");
		$finish;
	end

	// Receiver: random stall bursts, one long hold-off on request.
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (300) @(negedge clk);
				hold_request = 1'b0;
				out_stall <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 18);
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one sample word, possibly after a random gap.
	task automatic send_sample(logic [tak_pkg::ADC_W-1:0] smp);
		int n;
		if (!quiet_tail && $urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_valid <= 1'b1;
		adc_sample <= smp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_count++;
		@(negedge clk);
	endtask

	// Drain the pipeline, then write one register while idle.
	task automatic write_reg(tak_pkg::reg_idx_t idx, logic [tak_pkg::COEF_W-1:0] val);
		in_valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Mostly readings spread over the full range, with the rails and small values mixed in.
	function automatic logic [tak_pkg::ADC_W-1:0] random_sample();
		case ($urandom_range(0, 9))
			0: return tak_pkg::ADC_W'($urandom_range(0, 3));
			1: return tak_pkg::ADC_W'($urandom_range(1020, 1023));
			default: return tak_pkg::ADC_W'($urandom());
		endcase
	endfunction

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++)
			send_sample(random_sample());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		adc_sample = '0;
		wr_en = 1'b0;
		wr_index = tak_pkg::REG_COEF_A;
		wr_data = '0;
		sent_count = 0;
		quiet_tail = 1'b0;
		hold_request = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: zero, rails, every single-bit sample.
		send_sample(10'd0);
		send_sample(10'd1);
		send_sample(10'd1023);
		send_sample(10'd512);
		for (int b = 0; b < tak_pkg::ADC_W; b++)
			send_sample(10'd1 << b);
		send_sample(10'h155);
		send_sample(10'h2AA);

		// Zero divider: the resistance truncates to zero for every sample.
		write_reg(tak_pkg::REG_DIVIDER, 32'd0);
		for (int s = 0; s < 4; s++)
			send_sample(tak_pkg::ADC_W'(s));
		send_sample(10'd1023);

		// Zero denominator, then negative denominator.
		write_reg(tak_pkg::REG_COEF_A, 32'd0);
		write_reg(tak_pkg::REG_COEF_B, 32'd0);
		write_reg(tak_pkg::REG_COEF_C, 32'd0);
		write_reg(tak_pkg::REG_DIVIDER, 32'd32500);
		send_sample(10'd300);
		write_reg(tak_pkg::REG_COEF_A, 32'h8000_0000);
		send_sample(10'd300);
		send_sample(10'd1023);

		// Default coefficients, with a long output hold-off while samples keep coming.
		write_reg(tak_pkg::REG_COEF_A, tak_pkg::COEF_A_RST);
		write_reg(tak_pkg::REG_COEF_B, tak_pkg::COEF_B_RST);
		write_reg(tak_pkg::REG_COEF_C, tak_pkg::COEF_C_RST);
		hold_request = 1'b1;
		random_phase(400);

		// Largest divider and extreme coefficients.
		write_reg(tak_pkg::REG_DIVIDER, 32'hF_FFFF);
		write_reg(tak_pkg::REG_COEF_C, 32'h7FFF_FFFF);
		write_reg(tak_pkg::REG_COEF_B, 32'h8000_0000);
		random_phase(250);
		write_reg(tak_pkg::REG_COEF_A, 32'h7FFF_FFFF);
		write_reg(tak_pkg::REG_COEF_B, 32'h7FFF_FFFF);
		write_reg(tak_pkg::REG_COEF_C, 32'h8000_0000);
		random_phase(250);

		// Random settings.
		for (int k = 0; k < 3; k++) begin
			write_reg(tak_pkg::REG_COEF_A, $urandom());
			write_reg(tak_pkg::REG_COEF_B,
				$urandom_range(0, 1) ? $urandom() : $urandom_range(0, 400000000));
			write_reg(tak_pkg::REG_COEF_C,
				$urandom_range(0, 1) ? $urandom() : $urandom_range(0, 2000000));
			write_reg(tak_pkg::REG_DIVIDER, $urandom_range(1, 1048575));
			random_phase(200);
		end

		// Back to defaults, last stretch without idling.
		write_reg(tak_pkg::REG_COEF_A, tak_pkg::COEF_A_RST);
		write_reg(tak_pkg::REG_COEF_B, tak_pkg::COEF_B_RST);
		write_reg(tak_pkg::REG_COEF_C, tak_pkg::COEF_C_RST);
		write_reg(tak_pkg::REG_DIVIDER, tak_pkg::COEF_W'(tak_pkg::DIVIDER_RST));
		quiet_tail = 1'b1;
		random_phase(300);
		in_valid <= 1'b0;

		while (pending_count != 0)
			@(negedge clk);
		repeat (PIPE_LATENCY + 10) @(negedge clk);

		$display("Sent %0d sample words over several coefficient and divider settings;",
			sent_count);
		$display("checked %0d results, %0d with domain error, %0d saturated.",
			result_count, domain_count, sat_count);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
